// ===== src/wvm_pkg.sv =====
// Shared widths, codes and types for the wavetable voice mixer.
// No dependencies; every other file of the block refers to it.
`default_nettype none
package wvm_pkg;

    localparam int MODE_W      = 2;
    localparam int VOICE_W     = 5;
    localparam int REG_IDX_W   = 4;
    localparam int WORD_W      = 16;
    localparam int MEM_ADDR_W  = 20;
    localparam int BYTE_W      = 8;
    localparam int SAMPLE_W    = 16;
    localparam int MASK_W      = 32;
    localparam int RATE_W      = 17;
    localparam int CFG_IDX_W   = 2;

    localparam int DEF_VOICES           = 32;
    localparam int DEF_SAMPLE_ADDR_BITS = 20;
    localparam int REGS_PER_VOICE       = 16;

    localparam int DIV_W  = 35;
    localparam int DIV_CW = 6;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_SMEM_WR = 2'd0,
        MODE_REG_WR  = 2'd1,
        MODE_REG_RD  = 2'd2,
        MODE_MIX     = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                   mode;
        logic [VOICE_W-1:0]      voice;
        logic [REG_IDX_W-1:0]    reg_index;
        logic [WORD_W-1:0]       reg_value;
        logic [MEM_ADDR_W-1:0]   mem_addr;
        logic [BYTE_W-1:0]       mem_byte;
    } t_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage
`default_nettype wire

// ===== src/wvm_if.sv =====
// Word channels of the wavetable voice mixer: command in, result out.
// Depends on wvm_pkg for field widths.
`default_nettype none
interface wvm_in_if;
    logic                              valid;
    logic                              ready;
    logic [wvm_pkg::MODE_W-1:0]        mode;
    logic [wvm_pkg::VOICE_W-1:0]       voice;
    logic [wvm_pkg::REG_IDX_W-1:0]     reg_index;
    logic [wvm_pkg::WORD_W-1:0]        reg_value;
    logic [wvm_pkg::MEM_ADDR_W-1:0]    mem_addr;
    logic [wvm_pkg::BYTE_W-1:0]        mem_byte;

    modport source (output valid, mode, voice, reg_index, reg_value, mem_addr, mem_byte,
                    input ready);
    modport sink   (input valid, mode, voice, reg_index, reg_value, mem_addr, mem_byte,
                    output ready);
endinterface

interface wvm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [wvm_pkg::SAMPLE_W-1:0] right_sample;
    logic signed [wvm_pkg::SAMPLE_W-1:0] left_sample;
    logic [wvm_pkg::WORD_W-1:0]        read_value;
    logic [wvm_pkg::MASK_W-1:0]        wave_irq_mask;
    logic [wvm_pkg::MASK_W-1:0]        ramp_irq_mask;

    modport source (output valid, right_sample, left_sample, read_value, wave_irq_mask,
                    ramp_irq_mask, input ready);
    modport sink   (input valid, right_sample, left_sample, read_value, wave_irq_mask,
                    ramp_irq_mask, output ready);
endinterface
`default_nettype wire

// ===== src/wvm_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on wvm_pkg for widths and the status struct.
`default_nettype none
module wvm_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [wvm_pkg::DIV_W-1:0]       i_dividend,
    input  wire logic [wvm_pkg::RATE_W-1:0]      i_divisor,
    output logic      [wvm_pkg::DIV_W-1:0]       o_quotient,
    output wvm_pkg::t_div_stat                   o_stat
);
    logic [wvm_pkg::DIV_W-1:0]  r_quo;
    logic [wvm_pkg::RATE_W-1:0] r_rem;
    logic [wvm_pkg::RATE_W-1:0] r_dvs;
    logic [wvm_pkg::DIV_CW-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [wvm_pkg::RATE_W:0]   trial;
    logic [wvm_pkg::RATE_W:0]   diff;
    logic                       ge;

    assign trial = {r_rem, r_quo[wvm_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= wvm_pkg::DIV_CW'(wvm_pkg::DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[wvm_pkg::DIV_W-2:0], ge};
            r_rem <= ge ? diff[wvm_pkg::RATE_W-1:0] : trial[wvm_pkg::RATE_W-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule
`default_nettype wire

// ===== src/wvm_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on wvm_pkg for operand widths.
`default_nettype none
module wvm_mul (
    input  wire logic                                   i_clk,
    input  wire logic signed [wvm_pkg::MUL_A_W-1:0]     i_a,
    input  wire logic signed [wvm_pkg::MUL_B_W-1:0]     i_b,
    output logic      signed [wvm_pkg::MUL_P_W-1:0]     o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule
`default_nettype wire

// ===== src/wavetable_voice_mixer.sv =====
// Top level: sequencer, voice register and sample memories, mixing datapath.
// Depends on wvm_pkg, wvm_if, wvm_div and wvm_mul.
//
//  port      dir  handshake      contents
//  i_in      in   valid/ready    mode, voice, reg_index, reg_value, mem_addr, mem_byte
//  o_out     out  valid/ready    right/left sample, read_value, wave/ramp IRQ masks
//  i_cfg_*   in   write enable   register index and data, no read-back
//
// Sample byte and register writes pass S_IDLE, S_CMD and S_DONE; a register read
// adds S_RVAL. A mix frame runs four divisions on the shared bit-serial divider
// for each active voice, none for a stopped voice. After reset the voice
// registers are cleared with i_in.ready low. One result register sits on the
// output; a finished item waits in its last state while that register is full,
// and a new word is taken only idle.
`default_nettype none
module wavetable_voice_mixer #(
    parameter int VOICES           = wvm_pkg::DEF_VOICES,
    parameter int SAMPLE_ADDR_BITS = wvm_pkg::DEF_SAMPLE_ADDR_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    wvm_in_if.sink                                 i_in,
    wvm_out_if.source                              o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [wvm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [wvm_pkg::RATE_W-1:0]        i_cfg_data
);
    localparam int NWORDS = VOICES * wvm_pkg::REGS_PER_VOICE;
    localparam int AW     = $clog2(NWORDS);
    localparam int SDEPTH = 1 << SAMPLE_ADDR_BITS;

    localparam logic [wvm_pkg::CFG_IDX_W-1:0] CFG_RUN  = 2'd0;
    localparam logic [wvm_pkg::CFG_IDX_W-1:0] CFG_VCNT = 2'd1;
    localparam logic [wvm_pkg::CFG_IDX_W-1:0] CFG_RATE = 2'd2;

    localparam logic [3:0] W_CTL  = 4'd0;
    localparam logic [3:0] W_RCTL = 4'd5;
    localparam logic [3:0] W_VOL  = 4'd9;
    localparam logic [3:0] W_POSH = 4'd10;
    localparam logic [3:0] W_POSL = 4'd11;
    localparam logic [3:0] W_LAST = 4'd13;

    typedef enum logic [24:0] {
        S_CLR  = 25'h0000001, S_IDLE = 25'h0000002, S_CMD  = 25'h0000004,
        S_RVAL = 25'h0000008, S_VRD  = 25'h0000010, S_VCHK = 25'h0000020,
        S_D1   = 25'h0000040, S_D1W  = 25'h0000080, S_D2   = 25'h0000100,
        S_D2W  = 25'h0000200, S_D3   = 25'h0000400, S_D3W  = 25'h0000800,
        S_D4   = 25'h0001000, S_D4W  = 25'h0002000, S_SRD  = 25'h0004000,
        S_M1   = 25'h0008000, S_M2   = 25'h0010000, S_M3   = 25'h0020000,
        S_M4   = 25'h0040000, S_M5   = 25'h0080000, S_M6   = 25'h0100000,
        S_M7   = 25'h0200000, S_M8   = 25'h0400000, S_WB   = 25'h0800000,
        S_DONE = 25'h1000000
    } t_state;

    function automatic logic [AW-1:0] f_vaddr(input logic [4:0] v, input logic [3:0] i);
        logic [8:0] t;
        t = {v, i};
        return t[AW-1:0];
    endfunction

    function automatic logic signed [16:0] f_tdiv512(input logic signed [50:0] p);
        logic signed [50:0] s;
        s = p + (p[50] ? 51'sd511 : 51'sd0);
        return 17'(s >>> 9);
    endfunction

    t_state                r_state;
    wvm_pkg::t_item        r_item;
    logic [3:0]            r_cnt;
    logic [AW-1:0]         r_clr;
    logic [4:0]            r_v;
    logic [15:0]           r_w [0:13];
    logic [15:0]           r_ctl, r_rc;
    logic [31:0]           r_pos, r_vol32, r_inc, r_vinc;
    logic [7:0]            r_b [0:3];
    logic signed [15:0]    r_t1, r_t2;
    logic signed [16:0]    r_a, r_mix;
    logic [15:0]           r_acc_r, r_acc_l, r_readv;
    logic                  r_run;
    logic [4:0]            r_vcm1;
    logic [16:0]           r_rate;
    logic [31:0]           r_wirq, r_rirq;
    logic                  r_ovalid;
    logic [15:0]           r_o_r, r_o_l, r_o_rd;
    logic [31:0]           r_o_wirq, r_o_rirq;

    logic [15:0]           r_vmem [0:NWORDS-1];
    logic [15:0]           r_vdata;
    logic [7:0]            r_smem [0:SDEPTH-1];
    logic [7:0]            r_sdata;

    logic                  vm_we;
    logic [AW-1:0]         vm_waddr, vm_raddr;
    logic [15:0]           vm_wdata;
    logic [SAMPLE_ADDR_BITS-1:0] sm_raddr;
    logic [19:0]           soff, saddr20;

    logic                  div_start;
    logic [34:0]           div_dvd;
    logic [16:0]           div_dvs;
    logic [34:0]           div_q;
    wvm_pkg::t_div_stat    div_st;
    logic signed [32:0]    mul_a;
    logic signed [17:0]    mul_b;
    logic signed [50:0]    prod;

    logic [16:0]           rate_eff, vdivisor;
    logic [4:0]            last_v;
    logic                  in_range;
    logic [15:0]           ctl0, rc0;
    logic [3:0]            vsh;
    logic [14:0]           vi;
    logic [23:0]           vol_w;
    logic [14:0]           volume;
    logic signed [15:0]    s1, s2;
    logic [8:0]            frac;
    logic [3:0]            pan;
    logic [31:0]           svol, evol, lstart, lend;
    logic [15:0]           n_rc, n_ctl;
    logic [31:0]           n_vol32, n_pos;
    logic                  n_rbit, n_wbit;
    logic [3:0]            wb_idx;
    logic [15:0]           wb_data;

    assign rate_eff = (r_rate == '0) ? 17'd1 : r_rate;
    assign vdivisor = 17'({1'b0, r_vcm1} + 6'd1);
    assign last_v   = (6'(r_vcm1) > 6'(VOICES - 1)) ? 5'(VOICES - 1) : r_vcm1;
    assign in_range = 6'(r_item.voice) < 6'(VOICES);

    assign ctl0 = r_w[0] | (r_w[0][9] ? 16'h0100 : 16'h0000);
    assign rc0  = r_w[5] | (r_w[5][9] ? 16'h0100 : 16'h0000);

    assign vsh    = {1'b0, r_w[8][15:14], 1'b0} + {2'b00, r_w[8][15:14]};
    assign vi     = {r_w[8][13:8], 9'd0} >> vsh;
    assign vol_w  = 24'({1'b1, r_vol32[16:9]}) << r_vol32[20:17];
    assign volume = 15'(vol_w >> 9);
    assign s1     = r_ctl[10] ? {r_b[1], r_b[0]} : {r_b[0], 8'h00};
    assign s2     = r_ctl[10] ? {r_b[3], r_b[2]} : {r_b[1], 8'h00};
    assign frac   = r_pos[8:0];
    assign pan    = r_w[13][11:8];
    assign svol   = {11'd0, r_w[6][15:8], 13'd0};
    assign evol   = {11'd0, r_w[7][15:8], 13'd0};
    assign lstart = {r_w[1], r_w[2]};
    assign lend   = {r_w[3], r_w[4]};

    // 16-bit data: bank bits kept, word offset doubled
    assign soff = r_ctl[10] ? ({r_pos[28:27], 18'd0} + {1'b0, r_pos[25:9], 1'b0})
                            : r_pos[28:9];
    assign saddr20  = soff + 20'(r_cnt);
    assign sm_raddr = saddr20[SAMPLE_ADDR_BITS-1:0];

    // volume ramp step
    always_comb begin
        n_rc    = r_rc;
        n_vol32 = r_vol32;
        if (!r_rc[8]) begin
            n_vol32 = r_vol32 + r_vinc;
            if (r_rc[14] ? (n_vol32 <= svol) : (n_vol32 >= evol)) begin
                if (r_rc[13]) n_rc[15] = 1'b1;
                if (r_rc[11]) begin
                    if (r_rc[12]) n_rc[14] = ~r_rc[14];
                    else          n_vol32 = r_rc[14] ? evol : svol;
                end else begin
                    n_rc[8] = 1'b1;
                    n_vol32 = r_rc[14] ? svol : evol;
                end
            end
        end
        n_rbit = n_rc[15] & n_rc[13];
        if (!n_rbit) n_rc = n_rc & 16'h7f00;
    end

    // position step, after the ramp step has updated r_rc
    always_comb begin
        n_ctl = r_ctl;
        n_pos = r_pos;
        if (!r_ctl[8]) begin
            n_pos = r_pos + r_inc;
            if (r_ctl[14] ? (n_pos <= lstart) : (n_pos >= lend)) begin
                if (r_ctl[13]) n_ctl[15] = 1'b1;
                if (r_ctl[11]) begin
                    if (r_ctl[12]) n_ctl[14] = ~r_ctl[14];
                    else           n_pos = r_ctl[14] ? lend : lstart;
                end else if (!r_rc[10]) begin
                    n_ctl[8] = 1'b1;
                end
            end
        end
        n_wbit = n_ctl[15] & n_ctl[13];
        if (!n_wbit) n_ctl = n_ctl & 16'h7f00;
    end

    always_comb begin
        unique case (r_cnt)
            4'd0:    begin wb_idx = W_CTL;  wb_data = r_ctl;          end
            4'd1:    begin wb_idx = W_RCTL; wb_data = r_rc;           end
            4'd2:    begin wb_idx = W_VOL;  wb_data = r_vol32[20:5];  end
            4'd3:    begin wb_idx = W_POSH; wb_data = r_pos[31:16];   end
            default: begin wb_idx = W_POSL; wb_data = r_pos[15:0];    end
        endcase
    end

    // voice register memory port
    always_comb begin
        vm_we    = 1'b0;
        vm_waddr = '0;
        vm_wdata = '0;
        vm_raddr = '0;
        unique case (r_state)
            S_CLR: begin
                vm_we    = 1'b1;
                vm_waddr = r_clr;
            end
            S_CMD: begin
                vm_we    = (r_item.mode == wvm_pkg::MODE_REG_WR) && in_range;
                vm_waddr = f_vaddr(r_item.voice, r_item.reg_index);
                vm_wdata = r_item.reg_value;
                vm_raddr = f_vaddr(r_item.voice, r_item.reg_index);
            end
            S_VRD: vm_raddr = f_vaddr(r_v, r_cnt);
            S_WB: begin
                vm_we    = 1'b1;
                vm_waddr = f_vaddr(r_v, wb_idx);
                vm_wdata = wb_data;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (vm_we) r_vmem[vm_waddr] <= vm_wdata;
        r_vdata <= r_vmem[vm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CMD && r_item.mode == wvm_pkg::MODE_SMEM_WR)
            r_smem[r_item.mem_addr[SAMPLE_ADDR_BITS-1:0]] <= r_item.mem_byte;
        r_sdata <= r_smem[sm_raddr];
    end

    // shared units
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = rate_eff;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            S_VCHK: begin mul_a = 33'(r_w[12]); mul_b = 18'd44100; end
            S_D1:   begin div_start = 1'b1; div_dvd = 35'(prod[31:0]); end
            S_D1W:  begin mul_a = 33'(div_q[31:0]); mul_b = 18'd7; end
            S_D2:   begin div_start = 1'b1; div_dvd = prod[34:0]; div_dvs = vdivisor; end
            S_D2W:  begin mul_a = 33'(vi); mul_b = 18'd44100; end
            S_D3:   begin div_start = 1'b1; div_dvd = 35'(prod[31:1]); end
            S_D3W:  begin mul_a = 33'(div_q[31:0]); mul_b = 18'd14; end
            S_D4:   begin div_start = 1'b1; div_dvd = prod[34:0]; div_dvs = vdivisor; end
            S_M1:   begin mul_a = 33'(s1); mul_b = 18'(volume); end
            S_M2:   begin mul_a = 33'(s2); mul_b = 18'(volume); end
            S_M3:   begin mul_a = 33'(r_t1); mul_b = 18'(10'd512 - 10'(frac)); end
            S_M4:   begin mul_a = 33'(r_t2); mul_b = 18'(frac); end
            S_M6:   begin mul_a = 33'(r_mix); mul_b = 18'(pan); end
            S_M7:   begin mul_a = 33'(r_mix); mul_b = 18'(4'd15 - pan); end
            default: ;
        endcase
    end

    wvm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quotient (div_q),
        .o_stat     (div_st)
    );

    wvm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_vcm1 <= 5'd13;
            r_rate <= 17'd44100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RUN:  r_run  <= i_cfg_data[0];
                CFG_VCNT: r_vcm1 <= i_cfg_data[4:0];
                CFG_RATE: r_rate <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_v      <= '0;
            r_wirq   <= '0;
            r_rirq   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(NWORDS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_item.mode      <= wvm_pkg::t_mode'(i_in.mode);
                        r_item.voice     <= i_in.voice;
                        r_item.reg_index <= i_in.reg_index;
                        r_item.reg_value <= i_in.reg_value;
                        r_item.mem_addr  <= i_in.mem_addr;
                        r_item.mem_byte  <= i_in.mem_byte;
                        r_state          <= S_CMD;
                    end
                end
                S_CMD: begin
                    r_acc_r <= '0;
                    r_acc_l <= '0;
                    r_readv <= '0;
                    r_v     <= '0;
                    r_cnt   <= '0;
                    unique case (r_item.mode)
                        wvm_pkg::MODE_REG_RD: r_state <= S_RVAL;
                        wvm_pkg::MODE_MIX:    r_state <= r_run ? S_VRD : S_DONE;
                        default:              r_state <= S_DONE;
                    endcase
                end
                S_RVAL: begin
                    r_readv <= in_range ? r_vdata : 16'd0;
                    r_state <= S_DONE;
                end
                S_VRD: begin
                    if (r_cnt != '0) r_w[4'(r_cnt - 1'b1)] <= r_vdata;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == W_LAST + 4'd1) r_state <= S_VCHK;
                end
                S_VCHK: begin
                    r_ctl   <= ctl0;
                    r_rc    <= rc0;
                    r_pos   <= {r_w[10], r_w[11]};
                    r_vol32 <= {11'd0, r_w[9], 5'd0};
                    r_cnt   <= '0;
                    r_state <= (ctl0[8] & rc0[8]) ? S_WB : S_D1;
                end
                S_D1: r_state <= S_D1W;
                S_D1W: if (div_st.done) r_state <= S_D2;
                S_D2: r_state <= S_D2W;
                S_D2W: begin
                    if (div_st.done) begin
                        r_inc   <= r_ctl[14] ? (32'd0 - div_q[31:0]) : div_q[31:0];
                        r_state <= S_D3;
                    end
                end
                S_D3: r_state <= S_D3W;
                S_D3W: if (div_st.done) r_state <= S_D4;
                S_D4: r_state <= S_D4W;
                S_D4W: begin
                    if (div_st.done) begin
                        r_vinc  <= r_rc[14] ? (32'd0 - div_q[31:0]) : div_q[31:0];
                        r_cnt   <= '0;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    if (r_cnt != '0) r_b[2'(r_cnt - 1'b1)] <= r_sdata;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd4) r_state <= S_M1;
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_t1    <= 16'(prod >>> 16);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_t2    <= 16'(prod >>> 16);
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_a     <= f_tdiv512(prod);
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_mix     <= r_a + f_tdiv512(prod);
                    r_rc      <= n_rc;
                    r_vol32   <= n_vol32;
                    r_rirq[r_v] <= n_rbit;
                    r_state   <= S_M6;
                end
                S_M6: begin
                    r_ctl     <= n_ctl;
                    r_pos     <= n_pos;
                    r_wirq[r_v] <= n_wbit;
                    r_state   <= S_M7;
                end
                S_M7: begin
                    r_acc_r <= r_acc_r + 16'(prod >>> 4);
                    r_state <= S_M8;
                end
                S_M8: begin
                    r_acc_l <= r_acc_l + 16'(prod >>> 4);
                    r_cnt   <= '0;
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd4) begin
                        r_cnt <= '0;
                        if (r_v == last_v) begin
                            r_state <= S_DONE;
                        end else begin
                            r_v     <= r_v + 1'b1;
                            r_state <= S_VRD;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_o_r    <= r_acc_r;
                        r_o_l    <= r_acc_l;
                        r_o_rd   <= r_readv;
                        r_o_wirq <= r_wirq;
                        r_o_rirq <= r_rirq;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ovalid;
    assign o_out.right_sample  = r_o_r;
    assign o_out.left_sample   = r_o_l;
    assign o_out.read_value    = r_o_rd;
    assign o_out.wave_irq_mask = r_o_wirq;
    assign o_out.ramp_irq_mask = r_o_rirq;

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_st.busy)
        else $error("divider restarted while busy");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> (r_state == S_D1W || r_state == S_D2W ||
                         r_state == S_D3W || r_state == S_D4W))
        else $error("divider finished outside a wait state");

    a_voice_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VRD) |-> (6'(r_v) < 6'(VOICES)))
        else $error("voice counter beyond the voice bank");

    a_accept_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_CMD))
        else $error("accepted word not decoded");
endmodule
`default_nettype wire
